>>> rtl/tpbu_pkg.sv
package tpbu_pkg;

  // Pipeline depth from input register to output register
  localparam int NUM_STAGES = 10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_ALPHA = 3'd4;

  // Blend mode codes
  localparam logic [2:0] MODE_NORMAL    = 3'd0;
  localparam logic [2:0] MODE_ADD       = 3'd1;
  localparam logic [2:0] MODE_SOFT_ADD  = 3'd2;
  localparam logic [2:0] MODE_MUL       = 3'd3;
  localparam logic [2:0] MODE_MUL_ALPHA = 3'd4;

  // Input word: source RGBA and destination RGB
  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
  } pix_in_t;

  // Output word: blended RGB
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pix_out_t;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  // Partial results one lane hands to the merge stage
  typedef struct packed {
    logic [7:0]  r0;    // normal blend result
    logic [8:0]  sum1;  // additive sum, unsaturated
    logic [8:0]  sum2;  // soft additive sum, unsaturated
    logic [7:0]  p3;    // multiplicative product
    logic [16:0] sum4;  // multiplicative-with-alpha numerator
    logic [7:0]  dst;   // destination channel
  } lane_res_t;

  // Floor of x / 255: fold the high byte back in until the remainder
  // fits, then one final correction
  function automatic logic [31:0] div255(input logic [31:0] x);
    logic [31:0] q;
    logic [31:0] r;
    q = {8'd0, x[31:8]};
    r = {24'd0, x[7:0]} + {8'd0, x[31:8]};
    for (int i = 0; i < 3; i++) begin
      q = q + {8'd0, r[31:8]};
      r = {24'd0, r[7:0]} + {8'd0, r[31:8]};
    end
    if (r >= 32'd255) begin
      q = q + 32'd1;
    end
    return q;
  endfunction

  // Clamp a 9-bit sum to 0..255
  function automatic logic [7:0] sat8(input logic [8:0] v);
    return v[8] ? 8'd255 : v[7:0];
  endfunction

endpackage

>>> rtl/tpbu_alpha.sv
module tpbu_alpha import tpbu_pkg::*; (
  input  logic       clk,
  input  pipe_ctl_t  ctl,
  input  logic [7:0] src_alpha,
  input  logic [7:0] tint_alpha,
  output logic [7:0] ea
);

  logic [15:0] sa_ta_r;
  logic [7:0]  ea_r;

  // Scale source alpha by the alpha tint
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      sa_ta_r <= 16'(src_alpha) * 16'(tint_alpha);
    end
  end

  // Effective alpha, floored
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      ea_r <= 8'(div255(32'(sa_ta_r)));
    end
  end

  assign ea = ea_r;

endmodule

>>> rtl/tpbu_lane.sv
module tpbu_lane import tpbu_pkg::*; (
  input  logic       clk,
  input  pipe_ctl_t  ctl,
  input  logic [2:0] mode,
  input  logic [7:0] src,
  input  logic [7:0] tint,
  input  logic [7:0] dst,
  input  logic [7:0] ea,
  output lane_res_t  res
);

  logic [15:0] st1_r, st2_r;
  logic [7:0]  d1_r, d2_r, d3_r, d4_r, d5_r, d6_r, d7_r, d8_r, d9_r;
  logic [7:0]  ea3_r, ea4_r, ea5_r, ea6_r, ea7_r;
  logic [15:0] de3_r, de4_r, de5_r, de6_r, de7_r, de8_r;
  logic [23:0] u3_r;
  logic [31:0] p4_r;
  logic [15:0] a0_4_r;
  logic [23:0] p1_5_r;
  logic [16:0] sum0_5_r;
  logic [7:0]  b1_5_r;
  logic [15:0] p2_6_r;
  logic [7:0]  r0_6_r, r0_7_r, r0_8_r, r0_9_r;
  logic [8:0]  sum1_6_r, sum1_7_r, sum1_8_r, sum1_9_r;
  logic [7:0]  p3_7_r, p3_8_r, p3_9_r;
  logic [15:0] t4_8_r;
  logic [8:0]  sum2_8_r, sum2_9_r;
  logic [16:0] sum4_9_r;
  logic [7:0]  fac;

  // Soft additive weights by the inverse destination
  assign fac = (mode == MODE_SOFT_ADD) ? ~d3_r : d3_r;

  // Stage 1: tinted source
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      st1_r <= 16'(src) * 16'(tint);
      d1_r  <= dst;
    end
  end

  // Stage 2: wait for effective alpha
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      st2_r <= st1_r;
      d2_r  <= d1_r;
    end
  end

  // Stage 3: apply alpha, form destination weight
  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      u3_r  <= 24'(st2_r) * 24'(ea);
      de3_r <= 16'(d2_r) * 16'(8'd255 - ea);
      ea3_r <= ea;
      d3_r  <= d2_r;
    end
  end

  // Stage 4: destination factor, first divide for normal and additive
  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      p4_r   <= 32'(u3_r) * 32'(fac);
      a0_4_r <= 16'(div255(32'(u3_r)));
      ea4_r  <= ea3_r;
      d4_r   <= d3_r;
      de4_r  <= de3_r;
    end
  end

  // Stage 5
  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      p1_5_r   <= 24'(div255(p4_r));
      sum0_5_r <= 17'(a0_4_r) + 17'(de4_r);
      b1_5_r   <= 8'(div255(32'(a0_4_r)));
      ea5_r    <= ea4_r;
      d5_r     <= d4_r;
      de5_r    <= de4_r;
    end
  end

  // Stage 6
  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      p2_6_r   <= 16'(div255(32'(p1_5_r)));
      r0_6_r   <= 8'(div255(32'(sum0_5_r)));
      sum1_6_r <= 9'(b1_5_r) + 9'(d5_r);
      ea6_r    <= ea5_r;
      d6_r     <= d5_r;
      de6_r    <= de5_r;
    end
  end

  // Stage 7: last divide of the product
  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      p3_7_r   <= 8'(div255(32'(p2_6_r)));
      r0_7_r   <= r0_6_r;
      sum1_7_r <= sum1_6_r;
      ea7_r    <= ea6_r;
      d7_r     <= d6_r;
      de7_r    <= de6_r;
    end
  end

  // Stage 8: reapply alpha to the product, soft additive sum
  always_ff @(posedge clk) begin
    if (ctl.load[7]) begin
      t4_8_r   <= 16'(p3_7_r) * 16'(ea7_r);
      sum2_8_r <= 9'(p3_7_r) + 9'(d7_r);
      p3_8_r   <= p3_7_r;
      r0_8_r   <= r0_7_r;
      sum1_8_r <= sum1_7_r;
      d8_r     <= d7_r;
      de8_r    <= de7_r;
    end
  end

  // Stage 9: blend product with destination
  always_ff @(posedge clk) begin
    if (ctl.load[8]) begin
      sum4_9_r <= 17'(t4_8_r) + 17'(de8_r);
      sum2_9_r <= sum2_8_r;
      p3_9_r   <= p3_8_r;
      r0_9_r   <= r0_8_r;
      sum1_9_r <= sum1_8_r;
      d9_r     <= d8_r;
    end
  end

  assign res.r0   = r0_9_r;
  assign res.sum1 = sum1_9_r;
  assign res.sum2 = sum2_9_r;
  assign res.p3   = p3_9_r;
  assign res.sum4 = sum4_9_r;
  assign res.dst  = d9_r;

endmodule

>>> rtl/tpbu_merge.sv
module tpbu_merge import tpbu_pkg::*; (
  input  logic       clk,
  input  pipe_ctl_t  ctl,
  input  logic [2:0] mode,
  input  lane_res_t  res_red,
  input  lane_res_t  res_green,
  input  lane_res_t  res_blue,
  output pix_out_t   pix
);

  pix_out_t pix_r;

  // Pick the channel result for the active mode
  function automatic logic [7:0] pick(input logic [2:0] m, input lane_res_t r);
    logic [7:0] v;
    case (m)
      MODE_NORMAL:    v = r.r0;
      MODE_ADD:       v = sat8(r.sum1);
      MODE_SOFT_ADD:  v = sat8(r.sum2);
      MODE_MUL:       v = r.p3;
      MODE_MUL_ALPHA: v = 8'(div255(32'(r.sum4)));
      default:        v = r.dst;
    endcase
    return v;
  endfunction

  // Output register: combine the three lanes into one word
  always_ff @(posedge clk) begin
    if (ctl.load[NUM_STAGES-1]) begin
      pix_r.out_red   <= pick(mode, res_red);
      pix_r.out_green <= pick(mode, res_green);
      pix_r.out_blue  <= pick(mode, res_blue);
    end
  end

  assign pix = pix_r;

endmodule

>>> rtl/tinted_pixel_blend_unit.sv
// Throughput: one word per cycle while the output is not stalled; ten pipeline
// stages, each with its own valid bit, and a stalled output holds only the full
// stages up to the first empty one, so bubbles close up.
// Reset (rst_n low, synchronous): clears all pipeline valid bits, sets the mix mode
// to normal and every tint to 255.
module tinted_pixel_blend_unit import tpbu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pix_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pix_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [2:0]            mix_mode_r;
  logic [7:0]            tint_red_r;
  logic [7:0]            tint_green_r;
  logic [7:0]            tint_blue_r;
  logic [7:0]            tint_alpha_r;
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  pipe_ctl_t             ctl;
  logic [7:0]            ea;
  lane_res_t             res_red, res_green, res_blue;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_mode_r   <= MODE_NORMAL;
      tint_red_r   <= 8'd255;
      tint_green_r <= 8'd255;
      tint_blue_r  <= 8'd255;
      tint_alpha_r <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIX_MODE:   mix_mode_r   <= cfg_data[2:0];
        REG_TINT_RED:   tint_red_r   <= cfg_data;
        REG_TINT_GREEN: tint_green_r <= cfg_data;
        REG_TINT_BLUE:  tint_blue_r  <= cfg_data;
        REG_TINT_ALPHA: tint_alpha_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage load enables: a stage advances when empty or when the next one advances
  always_comb begin
    ctl.load[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ctl.load[i] = !valid_r[i] || ctl.load[i+1];
    end
  end

  // Advance valid bits with the data
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.load[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (ctl.load[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = ctl.load[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  tpbu_alpha u_alpha (
    .clk        (clk),
    .ctl        (ctl),
    .src_alpha  (in_data.src_alpha),
    .tint_alpha (tint_alpha_r),
    .ea         (ea)
  );

  tpbu_lane u_lane_red (
    .clk  (clk),
    .ctl  (ctl),
    .mode (mix_mode_r),
    .src  (in_data.src_red),
    .tint (tint_red_r),
    .dst  (in_data.dst_red),
    .ea   (ea),
    .res  (res_red)
  );

  tpbu_lane u_lane_green (
    .clk  (clk),
    .ctl  (ctl),
    .mode (mix_mode_r),
    .src  (in_data.src_green),
    .tint (tint_green_r),
    .dst  (in_data.dst_green),
    .ea   (ea),
    .res  (res_green)
  );

  tpbu_lane u_lane_blue (
    .clk  (clk),
    .ctl  (ctl),
    .mode (mix_mode_r),
    .src  (in_data.src_blue),
    .tint (tint_blue_r),
    .dst  (in_data.dst_blue),
    .ea   (ea),
    .res  (res_blue)
  );

  tpbu_merge u_merge (
    .clk       (clk),
    .ctl       (ctl),
    .mode      (mix_mode_r),
    .res_red   (res_red),
    .res_green (res_green),
    .res_blue  (res_blue),
    .pix       (out_data)
  );

endmodule

>>> rtl/tpbu_checker.sv
module tpbu_checker import tpbu_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pix_out_t out_data,
  input logic     cfg_valid,
  input logic     cfg_ready
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed or dropped");

  // A free output side never blocks the input
  a_no_false_stall: assert property (@(posedge clk)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side is free");

  // Configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind tinted_pixel_blend_unit tpbu_checker u_tpbu_checker (.*);
